>>> sv/tmbg_pkg.sv
// ----------------------------------------------------------------------------
// tmbg_pkg: shared types and constants of the tile map background pixel block
// Video memory geometry, stream field widths, operation and register codes.
// ----------------------------------------------------------------------------
package tmbg_pkg;

  // Video memory geometry.
  localparam int VIDEO_WORDS = 262144;
  localparam int VADDR_W     = $clog2(VIDEO_WORDS);

  // Stream and configuration widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  typedef logic [VADDR_W-1:0] vaddr_t;
  typedef logic [15:0]        vword_t;

  // Write request into the video memory.
  typedef struct packed {
    logic   en;
    vaddr_t addr;
    vword_t data;
  } vram_wr_t;

  // Read request on one port of the video memory.
  typedef struct packed {
    logic   en;
    vaddr_t addr;
  } vram_rd_t;

  // Kind of an input beat, carried in tuser.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LAYER_ENABLE     = 3'd0,
    REG_DISPLAY_MODE     = 3'd1,
    REG_SCROLL_X         = 3'd2,
    REG_SCROLL_Y         = 3'd3,
    REG_MAP_BASE         = 3'd4,
    REG_BITMAP_PALETTE   = 3'd5,
    REG_BITMAP_BANK      = 3'd6,
    REG_INTERLACE_DOUBLE = 3'd7
  } reg_idx_t;

  // Bits of display_mode: bit 0 picks 16x16 cells, bit 1 picks the bitmap.
  localparam int MODE_TILE16_BIT = 0;
  localparam int MODE_BITMAP_BIT = 1;

endpackage

>>> sv/tmbg_vram.sv
// ----------------------------------------------------------------------------
// tmbg_vram: video memory with one write port and two read ports
// Synchronous reads with registered read data; a read that meets a write to
// the same word in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module tmbg_vram (
  input  logic              clk,
  input  tmbg_pkg::vram_wr_t wr,
  input  tmbg_pkg::vram_rd_t rd_a,
  output tmbg_pkg::vword_t  rdata_a,
  input  tmbg_pkg::vram_rd_t rd_b,
  output tmbg_pkg::vword_t  rdata_b
);
  import tmbg_pkg::*;

  vword_t mem [VIDEO_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port A: pattern words and bitmap words.
  always_ff @(posedge clk) begin
    if (rd_a.en) begin
      rdata_a <= mem[rd_a.addr];
    end
  end

  // Read port B: character row words.
  always_ff @(posedge clk) begin
    if (rd_b.en) begin
      rdata_b <= mem[rd_b.addr];
    end
  end

endmodule

>>> sv/tile_map_background_pixel.sv
// A render beat passes the stage 1 registers, the stage 2 registers and the output
// register, in that order, on its way to the output.
// Throughput: one beat per cycle while not stalled, writes and renders mixed freely.
// The rate is set by the video memory: port A reads the map or bitmap word, port B
// reads the character row word one stage later, and port W takes writes.
// A stall on the output holds the whole pipeline and the input together.
// ----------------------------------------------------------------------------
// tile_map_background_pixel: background layer pixel generator
// Holds video memory filled by write beats and returns a colour memory index
// and a transparent flag for each render beat, in tile or bitmap mode.
// Reset clears config and valid registers; video memory is undefined until written.
// ----------------------------------------------------------------------------
module tile_map_background_pixel (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [tmbg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tmbg_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: mem_addr[17:0], mem_data[33:18], screen_x[43:34], screen_line[51:44],
  //        field[52], zero fill above.
  input  logic [tmbg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op (0 writes a word, 1 renders a pixel).
  input  logic                                 s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: cram_index[10:0], zero fill above.
  output logic [tmbg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: transparent.
  output logic                                 m_axis_tuser
);
  import tmbg_pkg::*;

  // Configuration registers.
  logic        layer_enable;
  logic [1:0]  display_mode;
  logic [10:0] scroll_x;
  logic [10:0] scroll_y;
  logic [8:0]  map_base;
  logic [2:0]  bitmap_palette;
  logic        bitmap_bank;
  logic        interlace_double;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_enable     <= 1'b0;
      display_mode     <= 2'd0;
      scroll_x         <= 11'd0;
      scroll_y         <= 11'd0;
      map_base         <= 9'd0;
      bitmap_palette   <= 3'd0;
      bitmap_bank      <= 1'b0;
      interlace_double <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LAYER_ENABLE:     layer_enable     <= cfg_data[0];
        REG_DISPLAY_MODE:     display_mode     <= cfg_data[1:0];
        REG_SCROLL_X:         scroll_x         <= cfg_data[10:0];
        REG_SCROLL_Y:         scroll_y         <= cfg_data[10:0];
        REG_MAP_BASE:         map_base         <= cfg_data[8:0];
        REG_BITMAP_PALETTE:   bitmap_palette   <= cfg_data[2:0];
        REG_BITMAP_BANK:      bitmap_bank      <= cfg_data[0];
        REG_INTERLACE_DOUBLE: interlace_double <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic tile16;
  logic bitmap;
  assign tile16 = display_mode[MODE_TILE16_BIT];
  assign bitmap = display_mode[MODE_BITMAP_BIT];

  // Pipeline moves as a whole whenever the output register is free or drained.
  logic out_valid;
  logic advance;
  logic in_beat;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_beat       = s_axis_tvalid && advance;

  // Input field unpacking.
  op_t         in_op;
  logic [17:0] in_mem_addr;
  logic [15:0] in_mem_data;
  logic [9:0]  in_screen_x;
  logic [7:0]  in_screen_line;
  logic        in_field;
  assign in_op          = op_t'(s_axis_tuser);
  assign in_mem_addr    = s_axis_tdata[17:0];
  assign in_mem_data    = s_axis_tdata[33:18];
  assign in_screen_x    = s_axis_tdata[43:34];
  assign in_screen_line = s_axis_tdata[51:44];
  assign in_field       = s_axis_tdata[52];

  // Stage 0: layer row and column, then the map or bitmap word address.
  logic [8:0]  eff_line;
  logic [8:0]  py;
  logic [10:0] p;
  logic [5:0]  map_row;
  logic [7:0]  tile_x;
  logic [19:0] pat_addr;
  logic [17:0] bm_addr;
  logic [3:0]  sub_y;
  logic [3:0]  sub_x;

  always_comb begin
    eff_line = interlace_double ? {in_screen_line, in_field} : {1'b0, in_screen_line};
    py       = scroll_y[8:0] + eff_line;
    p        = {2'b00, scroll_x[8:0]} + {1'b0, in_screen_x};
    map_row  = tile16 ? {1'b0, py[8:4]} : py[8:3];
    tile_x   = tile16 ? {1'b0, p[10:4]} : p[10:3];
    sub_y    = tile16 ? py[3:0] : {1'b0, py[2:0]};
    sub_x    = tile16 ? p[3:0] : {1'b0, p[2:0]};
    // Map row holds 64 words; the column runs on past the row unwrapped.
    pat_addr = {1'b0, map_base, 10'd0} + {8'd0, map_row, 6'd0} + {12'd0, tile_x};
    // Bitmap word: 512 bytes per row, bank adds 64 Ki words.
    bm_addr  = {1'b0, py, p[8:1]} + {1'b0, bitmap_bank, 16'd0};
  end

  // Video memory requests.
  vram_wr_t vram_wr;
  vram_rd_t vram_rd_a;
  vram_rd_t vram_rd_b;
  vword_t   rdata_a;
  vword_t   rdata_b;

  assign vram_wr.en     = in_beat && (in_op == OP_WRITE);
  assign vram_wr.addr   = in_mem_addr[VADDR_W-1:0];
  assign vram_wr.data   = in_mem_data;
  assign vram_rd_a.en   = advance;
  assign vram_rd_a.addr = bitmap ? bm_addr[VADDR_W-1:0] : pat_addr[VADDR_W-1:0];

  tmbg_vram u_vram (
    .clk     (clk),
    .wr      (vram_wr),
    .rd_a    (vram_rd_a),
    .rdata_a (rdata_a),
    .rd_b    (vram_rd_b),
    .rdata_b (rdata_b)
  );

  // Stage 1 registers: what the row word lookup needs besides the map word.
  logic       s1_valid;
  logic [3:0] s1_sub_y;
  logic [3:0] s1_sub_x;
  logic       s1_px0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_beat && (in_op == OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sub_y <= sub_y;
      s1_sub_x <= sub_x;
      s1_px0   <= p[0];
    end
  end

  // Stage 1: decode pattern word, form character row word address, pick bitmap byte.
  logic        hflip;
  logic        vflip;
  logic [9:0]  chr;
  logic [3:0]  ey;
  logic [3:0]  pix;
  logic [17:0] row_addr;
  logic [7:0]  bm_byte;

  always_comb begin
    chr      = rdata_a[9:0];
    hflip    = rdata_a[10];
    vflip    = rdata_a[11];
    ey       = s1_sub_y ^ {4{vflip}};
    pix      = s1_sub_x ^ {4{hflip}};
    row_addr = tile16 ? {2'b00, chr, ey[3:0], pix[3:2]}
                      : {4'd0, chr, ey[2:0], pix[2]};
    // Even byte addresses sit in the high half of a word.
    bm_byte  = s1_px0 ? rdata_a[7:0] : rdata_a[15:8];
  end

  assign vram_rd_b.en   = advance;
  assign vram_rd_b.addr = row_addr[VADDR_W-1:0];

  // Stage 2 registers.
  logic       s2_valid;
  logic [3:0] s2_pal;
  logic [1:0] s2_nib_sel;
  logic [7:0] s2_bm_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pal     <= rdata_a[15:12];
      s2_nib_sel <= pix[1:0];
      s2_bm_byte <= bm_byte;
    end
  end

  // Stage 2: pick the nibble, most significant first, and build the index.
  logic [3:0]  nib;
  logic [7:0]  colour;
  logic [10:0] idx;

  always_comb begin
    unique case (s2_nib_sel)
      2'd0: nib = rdata_b[15:12];
      2'd1: nib = rdata_b[11:8];
      2'd2: nib = rdata_b[7:4];
      2'd3: nib = rdata_b[3:0];
      default: nib = 4'd0;
    endcase
    colour = bitmap ? s2_bm_byte : {4'd0, nib};
    idx    = bitmap ? {bitmap_palette, s2_bm_byte} : {3'd0, s2_pal, nib};
  end

  // Output register.
  logic [10:0] out_index;
  logic        out_transparent;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index       <= layer_enable ? idx : 11'd0;
      out_transparent <= !layer_enable || (colour == 8'd0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_index};
  assign m_axis_tuser  = out_transparent;

endmodule

>>> sv/tmbg_checker.sv
// ----------------------------------------------------------------------------
// tmbg_checker: port-level checks of the background pixel block
// Watches the stream ports for output hold, back pressure and latency.
// ----------------------------------------------------------------------------
module tmbg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tmbg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser
);
  import tmbg_pkg::*;

  logic render_beat;
  assign render_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RENDER);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // With the output register empty the block takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A render beat reaches the output when the output stays ready behind it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    render_beat ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("render result missing after three cycles");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat present right after reset");

endmodule

bind tile_map_background_pixel tmbg_checker u_tmbg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/tile_map_background_pixel_tb.sv
// ----------------------------------------------------------------------------
// tile_map_background_pixel_tb: self-checking bench of the background pixel block
// A queue of planned beats feeds a stream driver. Video memory is filled before
// any word is read, and each render beat is predicted when it is accepted.
// A monitor compares every output beat with the oldest predicted pixel, and
// both sides idle at random. Register writes happen only once the block is idle.
// ----------------------------------------------------------------------------
module tile_map_background_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmbg_pkg::*;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int RANDOM_PHASES = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int END_DRAIN     = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_PRINTED   = 40;

  // Shadow of the layer registers.
  typedef struct packed {
    logic        layer_enable;
    logic [1:0]  display_mode;
    logic [10:0] scroll_x;
    logic [10:0] scroll_y;
    logic [8:0]  map_base;
    logic [2:0]  bitmap_palette;
    logic        bitmap_bank;
    logic        interlace_double;
  } layer_cfg_t;

  typedef struct packed {
    logic [10:0] cram_index;
    logic        transparent;
  } pixel_t;

  typedef enum logic {
    ENTRY_BEAT,
    ENTRY_SETREG
  } entry_kind_t;

  // One planned step: either an input beat or a register write.
  typedef struct packed {
    entry_kind_t kind;
    op_t         op;
    vaddr_t      mem_addr;
    vword_t      mem_data;
    logic [9:0]  screen_x;
    logic [7:0]  screen_line;
    logic        field;
    reg_idx_t    reg_sel;
    logic [10:0] reg_value;
  } stream_entry_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: mem_addr[17:0], mem_data[33:18], screen_x[43:34], screen_line[51:44],
  //        field[52], zero fill above.
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: op.
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: cram_index[10:0], zero fill above.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: transparent.
  logic                   m_axis_tuser;

  // Planning side: what the stimulus will have written by each point.
  layer_cfg_t    planned_cfg = '0;
  vword_t        planned_vram [VIDEO_WORDS];
  bit            planned_written [VIDEO_WORDS];
  stream_entry_t pending[$];
  int unsigned   planned_beats = 0;

  // Prediction side: state as the block should hold it.
  layer_cfg_t    live_cfg = '0;
  vword_t        vram_copy [VIDEO_WORDS];
  pixel_t        pixels_due[$];

  stream_entry_t held;
  int unsigned   send_gap, quiet, tx_calm;
  int unsigned   stall_left, rx_calm;
  int unsigned   idle_cycles = 0;
  int unsigned   mismatches = 0;

  tile_map_background_pixel dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Address arithmetic of the layer, shared by planning and prediction.
  // ---------------------------------------------------------------------------

  function automatic layer_cfg_t apply_reg(layer_cfg_t c, reg_idx_t r, logic [10:0] v);
    case (r)
      REG_LAYER_ENABLE:     c.layer_enable     = v[0];
      REG_DISPLAY_MODE:     c.display_mode     = v[1:0];
      REG_SCROLL_X:         c.scroll_x         = v;
      REG_SCROLL_Y:         c.scroll_y         = v;
      REG_MAP_BASE:         c.map_base         = v[8:0];
      REG_BITMAP_PALETTE:   c.bitmap_palette   = v[2:0];
      REG_BITMAP_BANK:      c.bitmap_bank      = v[0];
      REG_INTERLACE_DOUBLE: c.interlace_double = v[0];
      default: ;
    endcase
    return c;
  endfunction

  // Layer row after interlace doubling and vertical scroll, modulo 512.
  function automatic logic [8:0] layer_row(layer_cfg_t c, logic [7:0] line, logic field);
    logic [8:0] eff;
    eff = c.interlace_double ? {line, field} : {1'b0, line};
    return c.scroll_y[8:0] + eff;
  endfunction

  // Byte address of a bitmap pixel: bank base plus row * 512 plus column.
  function automatic logic [18:0] bitmap_byte_addr(layer_cfg_t c, logic [9:0] sx,
                                                   logic [8:0] py);
    logic [8:0] px;
    px = c.scroll_x[8:0] + sx[8:0];
    return (c.bitmap_bank ? 19'h20000 : 19'h0) + {1'b0, py, px};
  endfunction

  // Word address of the pattern word; the tile column runs past the map width.
  function automatic vaddr_t map_word_addr(layer_cfg_t c, logic [9:0] sx, logic [8:0] py);
    int unsigned cell_px, p, byte_addr;
    cell_px = c.display_mode[MODE_TILE16_BIT] ? 16 : 8;
    p = int'(c.scroll_x[8:0]) + int'(sx);
    byte_addr = (int'(c.map_base) << 11) + (int'(py) / cell_px) * 128 + (p / cell_px) * 2;
    return vaddr_t'(byte_addr >> 1);
  endfunction

  // Word address of the character row word, with the nibble that holds the pixel.
  function automatic vaddr_t char_word_addr(layer_cfg_t c, vword_t pn, logic [9:0] sx,
                                            logic [8:0] py, output logic [1:0] nib);
    int unsigned cell_px, cmax, sub_y, sub_x, row_byte;
    cell_px = c.display_mode[MODE_TILE16_BIT] ? 16 : 8;
    cmax = cell_px - 1;
    sub_y = py & cmax;
    sub_x = (int'(c.scroll_x[8:0]) + int'(sx)) & cmax;
    if (pn[11]) sub_y = cmax - sub_y;
    if (pn[10]) sub_x = cmax - sub_x;
    row_byte = int'(pn[9:0]) * (cell_px * cell_px / 2) + sub_y * (cell_px / 2);
    nib = sub_x[1:0];
    return vaddr_t'((row_byte >> 1) + (sub_x >> 2));
  endfunction

  // Expected pixel of a render beat, from the predicted memory and registers.
  function automatic pixel_t render_pixel(stream_entry_t b);
    pixel_t      px;
    logic [8:0]  py;
    logic [18:0] baddr;
    vword_t      pn, w;
    vaddr_t      a;
    logic [1:0]  nib;
    logic [7:0]  col;
    if (!live_cfg.layer_enable) begin
      px.cram_index = '0;
      px.transparent = 1'b1;
      return px;
    end
    py = layer_row(live_cfg, b.screen_line, b.field);
    if (live_cfg.display_mode[MODE_BITMAP_BIT]) begin
      baddr = bitmap_byte_addr(live_cfg, b.screen_x, py);
      w = vram_copy[vaddr_t'(baddr >> 1)];
      col = baddr[0] ? w[7:0] : w[15:8];
      px.cram_index = {live_cfg.bitmap_palette, col};
    end else begin
      pn = vram_copy[map_word_addr(live_cfg, b.screen_x, py)];
      a = char_word_addr(live_cfg, pn, b.screen_x, py, nib);
      w = vram_copy[a];
      col = {4'h0, w[4 * (3 - int'(nib)) +: 4]};
      px.cram_index = {3'b000, pn[15:12], col[3:0]};
    end
    px.transparent = (col == 8'h00);
    return px;
  endfunction

  // Idle count for one beat; now and then a stretch with no idling at all.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 50);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------------

  task automatic push_beat(op_t op, vaddr_t a, vword_t d, logic [9:0] x, logic [7:0] line,
                           logic field);
    stream_entry_t e;
    e = '0;
    e.kind = ENTRY_BEAT;
    e.op = op;
    e.mem_addr = a;
    e.mem_data = d;
    e.screen_x = x;
    e.screen_line = line;
    e.field = field;
    pending.push_back(e);
    planned_beats++;
  endtask

  task automatic push_reg(reg_idx_t r, logic [10:0] v);
    stream_entry_t e;
    e = '0;
    e.kind = ENTRY_SETREG;
    e.reg_sel = r;
    e.reg_value = v;
    pending.push_back(e);
    planned_cfg = apply_reg(planned_cfg, r, v);
  endtask

  task automatic plan_setup(logic le, logic [1:0] mode, logic [10:0] sx, logic [10:0] sy,
                            logic [8:0] mb, logic [2:0] pal, logic bank, logic il);
    push_reg(REG_LAYER_ENABLE, 11'(le));
    push_reg(REG_DISPLAY_MODE, 11'(mode));
    push_reg(REG_SCROLL_X, sx);
    push_reg(REG_SCROLL_Y, sy);
    push_reg(REG_MAP_BASE, 11'(mb));
    push_reg(REG_BITMAP_PALETTE, 11'(pal));
    push_reg(REG_BITMAP_BANK, 11'(bank));
    push_reg(REG_INTERLACE_DOUBLE, 11'(il));
  endtask

  // Write beats carry random screen fields; the block ignores them.
  task automatic plan_write(vaddr_t a, vword_t d);
    planned_vram[a] = d;
    planned_written[a] = 1'b1;
    push_beat(OP_WRITE, a, d, 10'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // A value of -1 keeps a word already written, or fills it with random data.
  task automatic place_word(vaddr_t a, int value);
    if (value >= 0) plan_write(a, vword_t'(value));
    else if (!planned_written[a]) plan_write(a, vword_t'($urandom));
  endtask

  // Render one pixel, writing first every word that the render will read.
  task automatic plan_render(logic [9:0] x, logic [7:0] line, logic field, int pattern,
                             int pixel_word);
    logic [8:0]  py;
    logic [18:0] baddr;
    vaddr_t      a;
    logic [1:0]  nib;
    if (planned_cfg.layer_enable) begin
      py = layer_row(planned_cfg, line, field);
      if (planned_cfg.display_mode[MODE_BITMAP_BIT]) begin
        baddr = bitmap_byte_addr(planned_cfg, x, py);
        place_word(vaddr_t'(baddr >> 1), pixel_word);
      end else begin
        a = map_word_addr(planned_cfg, x, py);
        place_word(a, pattern);
        a = char_word_addr(planned_cfg, planned_vram[a], x, py, nib);
        place_word(a, pixel_word);
      end
    end
    push_beat(OP_RENDER, vaddr_t'($urandom), vword_t'($urandom), x, line, field);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents queued beats, writes registers once the block is idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    logic          present;
    logic          write_reg;
    stream_entry_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_we <= 1'b0;
      send_gap = 0;
      quiet = 0;
      tx_calm = 0;
      live_cfg = '0;
    end else begin
      present = s_axis_tvalid;
      write_reg = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        if (held.op == OP_WRITE) vram_copy[held.mem_addr] = held.mem_data;
        else pixels_due.push_back(render_pixel(held));
        present = 1'b0;
        send_gap = draw_wait(tx_calm);
        quiet = 0;
      end else if (quiet < SETTLE_CYCLES) begin
        quiet++;
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          if (pending[0].kind == ENTRY_BEAT) begin
            held = pending.pop_front();
            present = 1'b1;
            s_axis_tdata <= {3'b000, held.field, held.screen_line, held.screen_x,
                             held.mem_data, held.mem_addr};
            s_axis_tuser <= held.op;
          end else if (pixels_due.size() == 0 && quiet >= SETTLE_CYCLES) begin
            // Nothing in flight: write walks and trailing beats have settled.
            nxt = pending.pop_front();
            write_reg = 1'b1;
            cfg_index <= nxt.reg_sel;
            cfg_data <= nxt.reg_value;
            live_cfg = apply_reg(live_cfg, nxt.reg_sel, nxt.reg_value);
          end
        end
      end
      s_axis_tvalid <= present;
      cfg_we <= write_reg;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each result beat and stalls at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    pixel_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      rx_calm = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("result beat with no pixel pending, index %0h",
                                    m_axis_tdata[10:0]));
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata[10:0] !== want.cram_index)
            report_mismatch($sformatf("cram_index %0h, expected %0h",
                                      m_axis_tdata[10:0], want.cram_index));
          if (m_axis_tuser !== want.transparent)
            report_mismatch($sformatf("transparent %b, expected %b (index %0h)",
                                      m_axis_tuser, want.transparent, want.cram_index));
        end
        stall_left = draw_wait(rx_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Watchdog: ends the run when no beat or register write moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tile_map_background_pixel regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed cases, then random phases, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned goal;
    int          ph, k, roll, run_len, x, line_no, fld;

    // Layer off after reset: transparent with index zero, nothing is read.
    plan_render(10'd0, 8'd0, 1'b0, -1, -1);
    plan_write(vaddr_t'(VIDEO_WORDS - 1), 16'hFFFF);
    plan_write('0, 16'h0000);

    // 8x8 cells: top palette bank and character, then both flips on a zero colour.
    plan_setup(1'b1, 2'd0, 11'd0, 11'd0, 9'd0, 3'd0, 1'b0, 1'b0);
    plan_render(10'd5, 8'd3, 1'b0, 16'hF3FF, -1);
    plan_render(10'd2, 8'd9, 1'b0, 16'hAC05, 16'h0000);

    // 16x16 cells at the register extremes: the map address wraps at the end of
    // memory and the tile column runs past the map width.
    plan_setup(1'b1, 2'd1, 11'd2047, 11'd2047, 9'd511, 3'd7, 1'b1, 1'b1);
    plan_render(10'd1023, 8'd255, 1'b1, 16'h4ABC, -1);
    plan_render(10'd703, 8'd0, 1'b0, 16'h0800, 16'h1234);
    plan_render(10'd0, 8'd128, 1'b1, -1, -1);

    // Bitmap in the upper bank: even and odd bytes of one word, the far corner.
    plan_setup(1'b1, 2'd2, 11'd0, 11'd0, 9'd0, 3'd7, 1'b1, 1'b0);
    plan_render(10'd0, 8'd0, 1'b0, -1, 16'h00FF);
    plan_render(10'd1, 8'd0, 1'b0, -1, -1);
    plan_render(10'd511, 8'd255, 1'b0, -1, 16'h8001);

    // The undefined mode behaves as a bitmap.
    plan_setup(1'b1, 2'd3, 11'd300, 11'd100, 9'd5, 3'd0, 1'b0, 1'b1);
    plan_render(10'd1023, 8'd128, 1'b1, -1, 16'h0000);

    // Random phases: mostly runs of pixels along a scanline, some pattern
    // rewrites and some stray writes anywhere in memory.
    goal = planned_beats;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      plan_setup(ph != 5, 2'(ph % 4), 11'($urandom_range(0, 2047)),
                 11'($urandom_range(0, 2047)), 9'($urandom_range(0, 511)),
                 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      goal += RANDOM_ITEMS / RANDOM_PHASES;
      while (planned_beats < goal) begin
        roll = $urandom_range(0, 19);
        x = $urandom_range(0, 1023);
        line_no = $urandom_range(0, 255);
        fld = $urandom_range(0, 1);
        if (roll == 0) begin
          plan_write(vaddr_t'($urandom_range(0, VIDEO_WORDS - 1)), vword_t'($urandom));
        end else if (roll == 1) begin
          plan_render(10'(x), 8'(line_no), 1'(fld), $urandom_range(0, 65535), -1);
        end else begin
          run_len = $urandom_range(1, 12);
          for (k = 0; k < run_len; k++)
            plan_render(10'(x + k), 8'(line_no), 1'(fld), -1, -1);
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending.size() != 0 || s_axis_tvalid);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    if (mismatches == 0) begin
      $display("tile_map_background_pixel regression: pass");
    end else begin
      $display("tile_map_background_pixel regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tmbg_pkg.sv
sv/tmbg_vram.sv
sv/tile_map_background_pixel.sv
sv/tmbg_checker.sv
verif/tile_map_background_pixel_tb.sv
